// File: sv/msb_first_bit_field_reader_top_macros.svh
// Assertion helpers for the top-level RTL file.
// Each macro expects clk and rst_n in scope.
`ifndef MSB_FIRST_BIT_FIELD_READER_TOP_MACROS_SVH
`define MSB_FIRST_BIT_FIELD_READER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MBFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MBFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mbfr_pkg.sv
package mbfr_pkg;

  // Store depth; must be a power of two so that index wrap is a truncation.
  localparam int STORE_BYTES = 4096;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // Widths fixed by the word format.
  localparam int BYTE_ADDR_W = 12;
  localparam int POS_W       = 15;
  localparam int FWIDTH_W    = 6;
  localparam int FIELD_W     = 32;

  // A field spans up to this many store bytes.
  localparam int FETCH_BYTES = 5;
  localparam int CNT_W       = $clog2(FETCH_BYTES);
  localparam int WIN_W       = 8 * FETCH_BYTES;
  localparam int HOLD_W      = WIN_W - 8;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_UNSIGNED = 2'd1,
    KIND_SIGNED   = 2'd2,
    KIND_PADDING  = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } state_t;

  // Control handed from the fetch sequencer to the formatter.
  typedef struct packed {
    kind_t               kind;
    logic [2:0]          offs;
    logic [FWIDTH_W-1:0] width;   // already clamped to FIELD_W
  } fmt_ctrl_t;

  // Byte index of a bit position, wrapped to the store.
  function automatic addr_t pos_to_addr(input logic [POS_W-1:0] pos);
    logic [POS_W-4:0] idx;
    idx = pos[POS_W-1:3];
    return addr_t'(idx);
  endfunction

endpackage

// File: sv/msb_first_bit_field_reader_top.sv
// MSB-first bit-field reader.
// Input channel: a word is taken at a rising edge with start high and busy low.
// in_kind selects a byte write (in_byte_address, in_byte_value), an unsigned or
// sign-extended field read (in_bit_position, in_field_width, widths above 32
// clamp to 32, width 0 gives 0), or a padding read that returns the bits of
// the addressed byte from the start bit down to its LSB (0 if byte-aligned).
// Result channel: one word per read on out_field_value, flagged by out_strobe
// for exactly one cycle; the receiver cannot stall it, so it is never held.
// Writes produce no result and do not raise busy; a read may follow at once.
// Field reads pull five bytes through the single byte-wide read port, one per
// cycle, shifting them into the window; busy holds off new words until the
// last byte is issued, and the formatter then registers the result.
// Padding reads need one byte and do not raise busy: one per cycle.
// Store byte addresses wrap at the store depth.
// Reset (synchronous, rst_n low) clears state, count, finish flag and strobe
// only; the byte store has no reset and must be written before it is read.
`include "msb_first_bit_field_reader_top_macros.svh"

module msb_first_bit_field_reader_top
  import mbfr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_kind,
  input  logic [BYTE_ADDR_W-1:0] in_byte_address,
  input  logic [7:0]             in_byte_value,
  input  logic [POS_W-1:0]       in_bit_position,
  input  logic [FWIDTH_W-1:0]    in_field_width,
  output logic                   out_strobe,
  output logic [FIELD_W-1:0]     out_field_value
);

  // Byte store, one write and one registered read per cycle.
  logic [7:0] mem [STORE_BYTES];
  logic       mem_we;
  addr_t      mem_wa;
  logic       mem_re;
  addr_t      mem_ra;
  logic [7:0] rd_data_r;

  state_t     state_r,  state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  addr_t      addr_r,   addr_nxt;
  logic       fin_r,    fin_nxt;
  fmt_ctrl_t  ctrl_r,   ctrl_nxt;
  logic [HOLD_W-1:0] window_r;

  logic       accept;
  kind_t      kind;
  logic [FWIDTH_W-1:0] wsat;

  assign kind   = kind_t'(in_kind);
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign wsat   = (in_field_width > 6'(FIELD_W)) ? 6'(FIELD_W) : in_field_width;

  // Write port straight from the input word.
  assign mem_we = accept && (kind == KIND_WRITE);
  assign mem_wa = addr_t'(in_byte_address);

  // Read port: first byte issued on accept, the rest from the fetch counter.
  assign mem_re = (accept && (kind != KIND_WRITE)) || (state_r == ST_FETCH);
  assign mem_ra = (state_r == ST_FETCH) ? addr_r : pos_to_addr(in_bit_position);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= in_byte_value;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Sequencer: next state, fetch count and address, format control, and finish flag for the formatter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    ctrl_nxt  = ctrl_r;
    fin_nxt   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (kind != KIND_WRITE)) begin
          ctrl_nxt.kind  = kind;
          ctrl_nxt.offs  = in_bit_position[2:0];
          ctrl_nxt.width = wsat;
          if (kind == KIND_PADDING) begin
            // Single byte: hand it off next cycle.
            fin_nxt = 1'b1;
          end else begin
            state_nxt = ST_FETCH;
            cnt_nxt   = CNT_W'(FETCH_BYTES - 1);
            addr_nxt  = pos_to_addr(in_bit_position) + addr_t'(1);
          end
        end
      end
      ST_FETCH: begin
        addr_nxt = addr_r + addr_t'(1);
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          // Last byte issued; it lands in rd_data_r as fin_r rises to start the formatter.
          state_nxt = ST_IDLE;
          fin_nxt   = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // Payload: fetch address, format control, and the byte window.
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    ctrl_r <= ctrl_nxt;
    if (state_r == ST_FETCH) begin
      // Shift in the byte fetched the cycle before.
      window_r <= {window_r[HOLD_W-9:0], rd_data_r};
    end
  end

  mbfr_format u_format (
    .clk             (clk),
    .rst_n           (rst_n),
    .go              (fin_r),
    .ctrl            (ctrl_r),
    .win             ({window_r, rd_data_r}),
    .out_strobe      (out_strobe),
    .out_field_value (out_field_value)
  );

  // No store write can land while a field is being fetched.
  `MBFR_ASSERT_NOW(a_no_write_in_fetch, state_r == ST_FETCH, !mem_we,
    "store write during field fetch")
  // A field read holds the input off on the next cycle.
  `MBFR_ASSERT_NEXT(a_field_read_busy,
    accept && (kind == KIND_UNSIGNED || kind == KIND_SIGNED), busy,
    "field read accepted without entering fetch")
  // A padding read hands off its byte on the next cycle without stalling.
  `MBFR_ASSERT_NEXT(a_padding_fast, accept && (kind == KIND_PADDING),
    fin_r && !busy, "padding read did not finish in one cycle")
  // Every hand-off becomes exactly one result word.
  `MBFR_ASSERT_NEXT(a_fin_strobe, fin_r, out_strobe,
    "formatter hand-off produced no result")

endmodule

// File: sv/mbfr_format.sv
module mbfr_format
  import mbfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  fmt_ctrl_t          ctrl,
  input  logic [WIN_W-1:0]   win,
  output logic               out_strobe,
  output logic [FIELD_W-1:0] out_field_value
);

  logic               strobe_r;
  logic [FIELD_W-1:0] value_r;
  logic [FIELD_W-1:0] value_nxt;

  logic [5:0]         shamt;
  logic [WIN_W-1:0]   shifted;
  logic [FIELD_W-1:0] mask;
  logic [FIELD_W-1:0] field;
  logic [4:0]         sidx;
  logic [7:0]         pad_byte;

  always_comb begin
    // Right-align the field: it ends offs + width bits into the window.
    shamt    = 6'(6'(WIN_W) - 6'(ctrl.offs) - ctrl.width);
    shifted  = win >> shamt;
    mask     = {FIELD_W{1'b1}} >> (6'(FIELD_W) - ctrl.width);
    field    = shifted[FIELD_W-1:0] & mask;
    sidx     = 5'(ctrl.width - 6'd1);
    pad_byte = win[7:0] & (8'hFF >> ctrl.offs);
    case (ctrl.kind)
      KIND_UNSIGNED: value_nxt = field;
      KIND_SIGNED:   value_nxt = field[sidx] ? (field | ~mask) : field;
      KIND_PADDING:  value_nxt = (ctrl.offs == 3'd0) ? '0 : {{(FIELD_W-8){1'b0}}, pad_byte};
      default:       value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      value_r <= value_nxt;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_field_value = value_r;

endmodule
